// ===== rtl/core/salct_pkg.sv =====
// Shared types and constants of the set-associative LRU cache tracker.
`timescale 1ns / 1ps

package salct_pkg;

  // Field widths of the channels.
  localparam int FUNC_W     = 2;
  localparam int WORD_W     = 64;
  localparam int CNT_W      = 32;
  localparam int OUTCOME_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // Configuration register widths and reset values.
  localparam int SET_BITS_W = 4;
  localparam int OFFSET_W   = 5;
  localparam int WAYS_W     = 4;
  localparam logic [SET_BITS_W-1:0] SET_BITS_RST = 4'd4;
  localparam logic [OFFSET_W-1:0]   OFFSET_RST   = 5'd4;
  localparam logic [WAYS_W-1:0]     WAYS_RST     = 4'd1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS     = 2'd2;

  // Default geometry of the tag store.
  localparam int MAX_SETS_DEF = 256;
  localparam int MAX_WAYS_DEF = 8;

  // The masked set index is below 2**15, so 16 bits hold it and any reduced index.
  localparam int RED_W      = 16;
  localparam int RED_STEP_W = 4;
  localparam logic [RED_STEP_W-1:0] RED_TOP = 4'd15;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_MODIFY = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

  // Outcome codes of the first access.
  localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_MISS  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;
  localparam logic [OUTCOME_W-1:0] OUT_NONE  = 2'd3;

  // One way of one set in the tag store.
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] tag;
    logic [WORD_W-1:0] stamp;
  } line_t;

endpackage

// ===== rtl/core/salct_if.sv =====
// Channel interfaces of the cache tracker: access requests, results and configuration.
`timescale 1ns / 1ps

interface salct_req_if;
  logic                          valid;
  logic                          ready;
  logic [salct_pkg::FUNC_W-1:0]  func;
  logic [salct_pkg::WORD_W-1:0]  address;

  modport source (output valid, output func, output address, input ready);
  modport sink (input valid, input func, input address, output ready);
endinterface

interface salct_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [salct_pkg::OUTCOME_W-1:0] outcome;
  logic                            second_hit;
  logic [salct_pkg::CNT_W-1:0]     hit_total;
  logic [salct_pkg::CNT_W-1:0]     miss_total;
  logic [salct_pkg::CNT_W-1:0]     eviction_total;

  modport source (output valid, output outcome, output second_hit, output hit_total,
                  output miss_total, output eviction_total, input ready);
  modport sink (input valid, input outcome, input second_hit, input hit_total,
                input miss_total, input eviction_total, output ready);
endinterface

interface salct_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [salct_pkg::CFG_IDX_W-1:0]  index;
  logic [salct_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/salct_cmp.sv =====
// Shared 64-bit comparator used for set reduction, tag match and LRU search.
`timescale 1ns / 1ps

module salct_cmp (
  input  logic [salct_pkg::WORD_W-1:0] a,
  input  logic [salct_pkg::WORD_W-1:0] b,
  output logic                         eq,
  output logic                         lt
);
  import salct_pkg::*;

  // Equality and unsigned less-than of the same operand pair.
  assign eq = (a == b);
  assign lt = (a < b);

endmodule

// ===== rtl/core/set_assoc_lru_cache_tracker_top.sv =====
// Set-associative LRU cache tracker: tag store, access sequencer and running totals.
//
// Channels: req carries one access word (func, address), rsp returns one result
// word per access (outcome, second_hit and the running hit, miss and eviction
// totals), and cfg writes set_bits, offset_bits and ways_in_use by index.
// cfg is always ready; write it only while no access is in flight.
// After reset the block sweeps the tag store once to clear the valid bits: all
// MAX_SETS rounded up to a power of two times MAX_WAYS rounded up to a power of
// two entries (2048 with the defaults). req.ready stays low during the sweep.
// One access at a time: req is ready only while the sequencer is idle.
// An access steps through these states: one to form the set index, then, when
// MAX_SETS is not a power of two, a restoring reduction through the comparator;
// a read and an evaluate state per way looked at in the tag search, and after a
// miss with every way valid a read and an evaluate state per active way for the
// oldest-stamp search; then the write-back and the load of the result register.
// The single comparator and the single read port of the tag store make both
// searches visit one way at a time. A no-access word goes from accept straight
// to the result load. req is ready again once the sequencer returns to idle
// after the result loads, so the block takes no new word before it is through
// with the last. The result register holds its word while rsp.ready is low;
// the block still accepts the next access and waits only to hand over its result.
`timescale 1ns / 1ps

module set_assoc_lru_cache_tracker_top #(
  parameter int MAX_SETS = salct_pkg::MAX_SETS_DEF,
  parameter int MAX_WAYS = salct_pkg::MAX_WAYS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  salct_req_if.sink   req,
  salct_rsp_if.source rsp,
  salct_cfg_if.sink   cfg
);
  import salct_pkg::*;

  localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int MEM_AW    = SET_W + WAY_W;
  localparam int MEM_DEPTH = 1 << MEM_AW;
  localparam bit SETS_POW2 = (MAX_SETS > 1) && ((MAX_SETS & (MAX_SETS - 1)) == 0);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INDEX,
    S_REDUCE,
    S_P1_RD,
    S_P1_EV,
    S_P2_RD,
    S_P2_EV,
    S_WRITE,
    S_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [SET_BITS_W-1:0] set_bits;
  logic [OFFSET_W-1:0]   offset_bits;
  logic [WAYS_W-1:0]     ways_in_use;

  // Per-access working registers.
  logic [FUNC_W-1:0]     func;
  logic [WORD_W-1:0]     blk;
  logic [RED_W-1:0]      red;
  logic [RED_STEP_W-1:0] red_step;
  logic [WAY_W-1:0]      way;
  logic [WAY_W-1:0]      sel_way;
  logic                  found_inv;
  logic [WORD_W-1:0]     min_stamp;
  logic [OUTCOME_W-1:0]  outcome;
  logic                  second;

  // Running state.
  logic [WORD_W-1:0] access_time;
  logic [CNT_W-1:0]  hits;
  logic [CNT_W-1:0]  misses;
  logic [CNT_W-1:0]  evictions;
  logic [MEM_AW-1:0] clr_addr;

  // Result register.
  logic                 out_valid;
  logic [OUTCOME_W-1:0] out_outcome;
  logic                 out_second;
  logic [CNT_W-1:0]     out_hits;
  logic [CNT_W-1:0]     out_misses;
  logic [CNT_W-1:0]     out_evictions;

  // Tag store.
  line_t             line_mem [MEM_DEPTH];
  line_t             rd_line;
  line_t             mem_wdata;
  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr;
  logic [MEM_AW-1:0] mem_raddr;

  // Comparator operands and results.
  logic [WORD_W-1:0] cmp_a;
  logic [WORD_W-1:0] cmp_b;
  logic              cmp_eq;
  logic              cmp_lt;

  logic [WAY_W-1:0]  last_way;
  logic [RED_W-1:0]  set_mask;
  logic [WORD_W-1:0] red_sub;
  logic [SET_W-1:0]  set_idx;

  // Highest active way: zero ways count as one, too many saturate.
  always_comb begin
    if (ways_in_use == '0) begin
      last_way = '0;
    end else if (32'(ways_in_use) > MAX_WAYS) begin
      last_way = WAY_W'(MAX_WAYS - 1);
    end else begin
      last_way = WAY_W'(ways_in_use - 4'd1);
    end
  end

  // Set index mask and the shifted set count for the reduction step.
  assign set_mask = (RED_W'(1) << set_bits) - RED_W'(1);
  assign red_sub  = WORD_W'(MAX_SETS) << red_step;
  assign set_idx  = red[SET_W-1:0];

  // Operand selection for the shared comparator.
  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    case (state)
      S_REDUCE: begin
        cmp_a = WORD_W'(red);
        cmp_b = red_sub;
      end
      S_P1_EV: begin
        cmp_a = rd_line.tag;
        cmp_b = blk;
      end
      S_P2_EV: begin
        cmp_a = rd_line.stamp;
        cmp_b = min_stamp;
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  salct_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .eq (cmp_eq),
    .lt (cmp_lt)
  );

  // Tag store port control: the sweep after reset or the write-back of one way.
  assign mem_we    = (state == S_CLEAR) || (state == S_WRITE);
  assign mem_waddr = (state == S_CLEAR) ? clr_addr : {set_idx, sel_way};
  assign mem_raddr = {set_idx, way};

  always_comb begin
    if (state == S_CLEAR) begin
      mem_wdata = '0;
    end else begin
      mem_wdata.valid = 1'b1;
      mem_wdata.tag   = blk;
      mem_wdata.stamp = access_time;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_line <= line_mem[mem_raddr];
  end

  // Handshakes and result outputs.
  assign req.ready          = (state == S_IDLE);
  assign cfg.ready          = 1'b1;
  assign rsp.valid          = out_valid;
  assign rsp.outcome        = out_outcome;
  assign rsp.second_hit     = out_second;
  assign rsp.hit_total      = out_hits;
  assign rsp.miss_total     = out_misses;
  assign rsp.eviction_total = out_evictions;

  // Sequencer, counters, configuration and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      out_valid   <= 1'b0;
      access_time <= '0;
      hits        <= '0;
      misses      <= '0;
      evictions   <= '0;
      set_bits    <= SET_BITS_RST;
      offset_bits <= OFFSET_RST;
      ways_in_use <= WAYS_RST;
    end else begin
      // Configuration writes; an index past the list is dropped.
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_SET_BITS: set_bits    <= cfg.data[SET_BITS_W-1:0];
          REG_OFFSET:   offset_bits <= cfg.data[OFFSET_W-1:0];
          REG_WAYS:     ways_in_use <= cfg.data[WAYS_W-1:0];
          default: ;
        endcase
      end

      // The result word leaves; in the result state the load below decides instead.
      if (out_valid && rsp.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (req.valid) begin
            func <= req.func;
            blk  <= req.address >> offset_bits;
            if (req.func == FUNC_NONE) begin
              outcome <= OUT_NONE;
              second  <= 1'b0;
              state   <= S_DONE;
            end else begin
              state <= S_INDEX;
            end
          end
        end

        S_INDEX: begin
          red       <= blk[RED_W-1:0] & set_mask;
          red_step  <= RED_TOP;
          way       <= '0;
          found_inv <= 1'b0;
          state     <= SETS_POW2 ? S_P1_RD : S_REDUCE;
        end

        // Restoring reduction of the masked index modulo the set count.
        S_REDUCE: begin
          if (!cmp_lt) begin
            red <= red - red_sub[RED_W-1:0];
          end
          red_step <= red_step - 1'b1;
          if (red_step == '0) begin
            state <= S_P1_RD;
          end
        end

        S_P1_RD: begin
          state <= S_P1_EV;
        end

        // Tag search: first matching valid way, remembering the first free way.
        S_P1_EV: begin
          if (rd_line.valid && cmp_eq) begin
            sel_way <= way;
            outcome <= OUT_HIT;
            state   <= S_WRITE;
          end else begin
            if (!rd_line.valid && !found_inv) begin
              found_inv <= 1'b1;
              sel_way   <= way;
            end
            if (way == last_way) begin
              way <= '0;
              if (found_inv || !rd_line.valid) begin
                outcome <= OUT_MISS;
                state   <= S_WRITE;
              end else begin
                state <= S_P2_RD;
              end
            end else begin
              way   <= way + 1'b1;
              state <= S_P1_RD;
            end
          end
        end

        S_P2_RD: begin
          state <= S_P2_EV;
        end

        // Oldest-stamp search; a strictly smaller stamp wins, so ties keep the lower way.
        S_P2_EV: begin
          if ((way == '0) || cmp_lt) begin
            min_stamp <= rd_line.stamp;
            sel_way   <= way;
          end
          if (way == last_way) begin
            outcome <= OUT_EVICT;
            state   <= S_WRITE;
          end else begin
            way   <= way + 1'b1;
            state <= S_P2_RD;
          end
        end

        // Write-back of the touched way; a modify's store part always hits it.
        S_WRITE: begin
          hits      <= hits + CNT_W'(outcome == OUT_HIT) + CNT_W'(func == FUNC_MODIFY);
          misses    <= misses + CNT_W'(outcome != OUT_HIT);
          evictions <= evictions + CNT_W'(outcome == OUT_EVICT);
          second    <= (func == FUNC_MODIFY);
          state     <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid     <= 1'b1;
            out_outcome   <= outcome;
            out_second    <= second;
            out_hits      <= hits;
            out_misses    <= misses;
            out_evictions <= evictions;
            access_time   <= access_time + 1'b1;
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The hit total moves only in the write-back cycle.
  a_hits_write_only: assert property (@(posedge clk) disable iff (rst)
    (state != S_WRITE) |=> $stable(hits))
    else $error("hit total changed outside write-back");

  // An eviction bumps the eviction total by exactly one.
  a_evict_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE && outcome == OUT_EVICT) |=> (evictions == $past(evictions) + 32'd1))
    else $error("eviction total not advanced by one");

  // The set index is in range once the tag search starts.
  a_set_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_P1_RD) |-> (32'(set_idx) < MAX_SETS))
    else $error("set index out of range");

  // The written way lies among the active ways.
  a_way_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> (sel_way <= last_way))
    else $error("selected way beyond active ways");

endmodule
